/* rtl/core/aps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the archive path sanitizer.
// No dependencies; used by every module of the block.
package aps_pkg;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_EMPTY      = 4'd1;
  localparam logic [3:0] ST_ABSOLUTE   = 4'd2;
  localparam logic [3:0] ST_TRAVERSAL  = 4'd3;
  localparam logic [3:0] ST_CONTROL    = 4'd4;
  localparam logic [3:0] ST_TRAILING   = 4'd5;
  localparam logic [3:0] ST_INVALID    = 4'd6;
  localparam logic [3:0] ST_RESERVED   = 4'd7;
  localparam logic [3:0] ST_NORM_EMPTY = 4'd8;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One request from front to back: the results one input item causes, in order.
  typedef struct packed {
    logic       slash;
    logic       dot;
    logic       chr;
    logic [7:0] ch;
    logic       verdict;
    logic [3:0] status;
  } aps_cmd_t;

endpackage

/* rtl/core/aps_front.sv */
`timescale 1ns / 1ps
// Front end: accepts path bytes, tracks component state, classifies errors.
// Emits one request per item that causes results. Depends on aps_pkg.
module aps_front import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] path_byte,
  input  logic       no_byte,
  input  logic       end_of_path,
  input  logic       q_full,
  output logic       push,
  output aps_cmd_t   cmd
);

  logic [1:0]  pos, pos_next;
  logic        first_letter, first_letter_next;
  logic [3:0]  sticky, sticky_next;
  logic        nonempty, nonempty_next;
  logic [2:0]  clen, clen_next;
  logic        held, held_next;
  logic [31:0] bchars, bchars_next;
  logic [2:0]  blen, blen_next;
  logic        dot_seen, dot_seen_next;
  logic        only_dots, only_dots_next;
  logic [1:0]  flags, flags_next;
  logic [7:0]  prev, prev_next;
  logic        accept;

  function automatic logic [3:0] comp_status(
    input logic [2:0]  len,
    input logic        hd,
    input logic        od,
    input logic [1:0]  fl,
    input logic [7:0]  pc,
    input logic [31:0] bc,
    input logic [2:0]  bl
  );
    logic rsv;
    logic [7:0] dig;
    rsv = 1'b0;
    dig = bc[31:24];
    if (bl == 3'd3) begin
      rsv = (bc == {8'h00, "NOC"}) || (bc == {8'h00, "NRP"}) ||
            (bc == {8'h00, "XUA"}) || (bc == {8'h00, "LUN"});
    end else if (bl == 3'd4) begin
      rsv = ((bc[23:0] == "MOC") || (bc[23:0] == "TPL")) &&
            (dig >= "1") && (dig <= "9");
    end
    if (len == 3'd0 || (len == 3'd1 && hd)) return ST_OK;
    else if (len == 3'd2 && od)             return ST_TRAVERSAL;
    else if (fl[0])                         return ST_CONTROL;
    else if (pc == " " || pc == CH_DOT)     return ST_TRAILING;
    else if (fl[1])                         return ST_INVALID;
    else if (rsv)                           return ST_RESERVED;
    else                                    return ST_OK;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (cmd.slash || cmd.dot || cmd.chr || cmd.verdict);

  always_comb begin
    logic       sep;
    logic [7:0] up;
    logic [3:0] fin;
    pos_next          = pos;
    first_letter_next = first_letter;
    sticky_next       = sticky;
    nonempty_next     = nonempty;
    clen_next         = clen;
    held_next         = held;
    bchars_next       = bchars;
    blen_next         = blen;
    dot_seen_next     = dot_seen;
    only_dots_next    = only_dots;
    flags_next        = flags;
    prev_next         = prev;
    cmd               = '0;
    sep = (path_byte == CH_SLASH) || (path_byte == 8'h5C);
    up  = (path_byte >= "a" && path_byte <= "z") ? path_byte - 8'h20 : path_byte;
    fin = ST_OK;
    cmd.ch = path_byte;

    if (!no_byte) begin
      if (pos == 2'd0) begin
        if (sep) sticky_next = ST_ABSOLUTE;
        first_letter_next = (path_byte >= "A" && path_byte <= "Z") ||
                            (path_byte >= "a" && path_byte <= "z");
      end else if (pos == 2'd1 && path_byte == ":" && first_letter) begin
        sticky_next = ST_ABSOLUTE;
      end
      if (pos < 2'd2) pos_next = pos + 2'd1;
      if (sticky_next == ST_OK) begin
        if (sep) begin
          sticky_next    = comp_status(clen, held, only_dots, flags, prev, bchars, blen);
          clen_next      = '0;
          held_next      = 1'b0;
          bchars_next    = '0;
          blen_next      = '0;
          dot_seen_next  = 1'b0;
          only_dots_next = 1'b1;
          flags_next     = '0;
          prev_next      = '0;
        end else begin
          if (clen == 3'd0) begin
            if (path_byte == CH_DOT) begin
              held_next = 1'b1;
            end else begin
              cmd.slash     = nonempty;
              nonempty_next = 1'b1;
              cmd.chr       = 1'b1;
            end
          end else if (held) begin
            cmd.slash     = nonempty;
            nonempty_next = 1'b1;
            cmd.dot       = 1'b1;
            cmd.chr       = 1'b1;
            held_next     = 1'b0;
          end else begin
            cmd.chr = 1'b1;
          end
          if (clen < 3'd7) clen_next = clen + 3'd1;
          if (path_byte != CH_DOT) only_dots_next = 1'b0;
          if (path_byte < 8'h20) flags_next[0] = 1'b1;
          if (path_byte == "<" || path_byte == ">" || path_byte == ":" ||
              path_byte == 8'h22 || path_byte == "|" || path_byte == "?" ||
              path_byte == "*") begin
            flags_next[1] = 1'b1;
          end
          prev_next = path_byte;
          if (!dot_seen) begin
            if (path_byte == CH_DOT) begin
              dot_seen_next = 1'b1;
            end else if (blen < 3'd5) begin
              if (blen < 3'd4) bchars_next[{blen[1:0], 3'b000} +: 8] = up;
              blen_next = blen + 3'd1;
            end
          end
        end
      end
    end

    if (end_of_path) begin
      if (pos_next == 2'd0) begin
        fin = ST_EMPTY;
      end else if (sticky_next != ST_OK) begin
        fin = sticky_next;
      end else begin
        fin = comp_status(clen_next, held_next, only_dots_next, flags_next, prev_next,
                          bchars_next, blen_next);
        if (fin == ST_OK && !nonempty_next) fin = ST_NORM_EMPTY;
      end
      cmd.verdict       = 1'b1;
      cmd.status        = fin;
      pos_next          = '0;
      first_letter_next = 1'b0;
      sticky_next       = ST_OK;
      nonempty_next     = 1'b0;
      clen_next         = '0;
      held_next         = 1'b0;
      bchars_next       = '0;
      blen_next         = '0;
      dot_seen_next     = 1'b0;
      only_dots_next    = 1'b1;
      flags_next        = '0;
      prev_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      first_letter <= 1'b0;
      sticky       <= ST_OK;
      nonempty     <= 1'b0;
      clen         <= '0;
      held         <= 1'b0;
      bchars       <= '0;
      blen         <= '0;
      dot_seen     <= 1'b0;
      only_dots    <= 1'b1;
      flags        <= '0;
      prev         <= '0;
    end else if (accept) begin
      pos          <= pos_next;
      first_letter <= first_letter_next;
      sticky       <= sticky_next;
      nonempty     <= nonempty_next;
      clen         <= clen_next;
      held         <= held_next;
      bchars       <= bchars_next;
      blen         <= blen_next;
      dot_seen     <= dot_seen_next;
      only_dots    <= only_dots_next;
      flags        <= flags_next;
      prev         <= prev_next;
    end
  end

  a_sticky_mutes_bytes: assert property (@(posedge clk) disable iff (rst)
    (sticky != ST_OK) |-> !(cmd.slash || cmd.dot || cmd.chr))
    else $error("byte request issued after a sticky error");

endmodule

/* rtl/core/aps_queue.sv */
`timescale 1ns / 1ps
// Short request queue between front and back ends.
// Depends on aps_pkg for the request type and depth.
module aps_queue import aps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  aps_cmd_t wr_cmd,
  input  logic     pop,
  output aps_cmd_t head,
  output logic     full,
  output logic     empty
);

  aps_cmd_t         mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule

/* rtl/core/aps_back.sv */
`timescale 1ns / 1ps
// Back end: expands each queued request into result items, one per cycle while out_ready
// is high, through an output register. Depends on aps_pkg.
module aps_back import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  aps_cmd_t   head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       verdict_valid,
  output logic [3:0] status_code,
  output logic       run_last
);

  logic [2:0] done;
  logic [2:0] pend;
  logic [2:0] pick;
  logic       last;
  logic       load;
  logic [7:0] nx_char;
  logic       nx_cv;

  assign pend = {head.slash, head.dot, head.chr} & ~done;
  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && last;

  always_comb begin
    pick    = '0;
    nx_char = 8'h00;
    nx_cv   = 1'b0;
    last    = 1'b1;
    if (pend[2]) begin
      pick    = 3'b100;
      nx_char = CH_SLASH;
      nx_cv   = 1'b1;
      last    = !(pend[1] || pend[0] || head.verdict);
    end else if (pend[1]) begin
      pick    = 3'b010;
      nx_char = CH_DOT;
      nx_cv   = 1'b1;
      last    = !(pend[0] || head.verdict);
    end else if (pend[0]) begin
      pick    = 3'b001;
      nx_char = head.ch;
      nx_cv   = 1'b1;
      last    = !head.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      done      <= last ? 3'b000 : (done | pick);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char      <= nx_char;
      char_valid    <= nx_cv;
      verdict_valid <= !nx_cv;
      status_code   <= nx_cv ? ST_OK : head.status;
      run_last      <= last;
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid ^ verdict_valid))
    else $error("result is neither byte nor verdict, or both");
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict_valid) |-> run_last)
    else $error("verdict not marked last");

endmodule

/* rtl/core/archive_path_sanitizer_unit.sv */
`timescale 1ns / 1ps
// Archive path sanitizer: normalizes a path byte stream and ends it with a status.
// An item's results pass through the request queue and then the output register.
// Throughput: one input item per cycle while the queue has room; the back end gives
// one result per cycle while out_ready is high, and an item causes up to 4 results.
// A four-entry request queue decouples the two. Synchronous active-high reset.
module archive_path_sanitizer_unit import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] path_byte,
  input  logic       no_byte,
  input  logic       end_of_path,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       verdict_valid,
  output logic [3:0] status_code,
  output logic       run_last
);

  aps_cmd_t wr_cmd;
  aps_cmd_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  aps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .path_byte   (path_byte),
    .no_byte     (no_byte),
    .end_of_path (end_of_path),
    .q_full      (full),
    .push        (push),
    .cmd         (wr_cmd)
  );

  aps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  aps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .verdict_valid (verdict_valid),
    .status_code   (status_code),
    .run_last      (run_last)
  );

endmodule

/* verif/archive_path_sanitizer_checker.sv */
`timescale 1ns / 1ps
// Checker for the archive path sanitizer: predicts the results of every accepted
// request and compares them with the accepted results. Depends on aps_pkg.
module archive_path_sanitizer_checker import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] path_byte,
  input  logic       no_byte,
  input  logic       end_of_path,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       char_valid,
  input  logic       verdict_valid,
  input  logic [3:0] status_code,
  input  logic       run_last,
  output int         mismatches,
  output int         outstanding
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam int         PrintCap  = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       chr;
    logic       verdict;
    logic [3:0] status;
    logic       last;
  } path_result_t;

  path_result_t expected_q[$];
  path_result_t item_results[$];
  int           error_count;

  // path-level state
  logic [1:0]  byte_count;
  logic        first_letter;
  logic [3:0]  sticky;
  logic        emitted_any;
  // component-level state
  logic [2:0]  seg_len;
  logic        dot_pending;
  logic [31:0] base_chars;
  logic [2:0]  base_len;
  logic        ext_started;
  logic        all_dots;
  logic        has_ctrl;
  logic        has_bad;
  logic [7:0]  last_ch;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PrintCap) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void clear_segment();
    seg_len = 0;
    dot_pending = 0;
    base_chars = 0;
    base_len = 0;
    ext_started = 0;
    all_dots = 1;
    has_ctrl = 0;
    has_bad = 0;
    last_ch = 0;
  endfunction

  function automatic void reset_path();
    byte_count = 0;
    first_letter = 0;
    sticky = ST_OK;
    emitted_any = 0;
    clear_segment();
  endfunction

  function automatic void add_result(input logic [7:0] ch, input logic chr,
                                     input logic verdict, input logic [3:0] status);
    path_result_t r;
    r.ch = ch;
    r.chr = chr;
    r.verdict = verdict;
    r.status = status;
    r.last = 1'b0;
    item_results = {item_results, r};
  endfunction

  function automatic void open_output();
    if (emitted_any) add_result(CH_SLASH, 1'b1, 1'b0, ST_OK);
    emitted_any = 1;
  endfunction

  function automatic logic [23:0] pack_name(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    return {c, b, a};
  endfunction

  function automatic logic name_reserved();
    logic [23:0] stem;
    logic [7:0]  digit;
    stem = base_chars[23:0];
    digit = base_chars[31:24];
    if (base_len == 3)
      return stem == pack_name("C", "O", "N") || stem == pack_name("P", "R", "N") ||
             stem == pack_name("A", "U", "X") || stem == pack_name("N", "U", "L");
    if (base_len == 4)
      return (stem == pack_name("C", "O", "M") || stem == pack_name("L", "P", "T")) &&
             digit >= "1" && digit <= "9";
    return 1'b0;
  endfunction

  function automatic logic [3:0] close_segment();
    logic [3:0] st;
    if (seg_len == 0 || (seg_len == 1 && dot_pending)) st = ST_OK;
    else if (seg_len == 2 && all_dots) st = ST_TRAVERSAL;
    else if (has_ctrl) st = ST_CONTROL;
    else if (last_ch == CH_SPACE || last_ch == CH_DOT) st = ST_TRAILING;
    else if (has_bad) st = ST_INVALID;
    else if (name_reserved()) st = ST_RESERVED;
    else st = ST_OK;
    clear_segment();
    return st;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic       sep;
    logic [7:0] up;
    sep = (b == CH_SLASH) || (b == CH_BSLASH);
    if (byte_count == 0) begin
      if (sep) sticky = ST_ABSOLUTE;
      first_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    end else if (byte_count == 1 && b == CH_COLON && first_letter) begin
      sticky = ST_ABSOLUTE;
    end
    if (byte_count < 2) byte_count++;
    if (sticky != ST_OK) return;
    if (sep) begin
      sticky = close_segment();
      return;
    end
    if (seg_len == 0) begin
      if (b == CH_DOT) begin
        dot_pending = 1;
      end else begin
        open_output();
        add_result(b, 1'b1, 1'b0, ST_OK);
      end
    end else if (dot_pending) begin
      open_output();
      add_result(CH_DOT, 1'b1, 1'b0, ST_OK);
      add_result(b, 1'b1, 1'b0, ST_OK);
      dot_pending = 0;
    end else begin
      add_result(b, 1'b1, 1'b0, ST_OK);
    end
    if (seg_len < 7) seg_len++;
    if (b != CH_DOT) all_dots = 0;
    if (b < CH_SPACE) has_ctrl = 1;
    if (b == "<" || b == ">" || b == CH_COLON || b == "\"" || b == "|" || b == "?" ||
        b == "*") has_bad = 1;
    last_ch = b;
    if (!ext_started) begin
      if (b == CH_DOT) begin
        ext_started = 1;
      end else if (base_len < 5) begin
        up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
        if (base_len < 4) base_chars[8*base_len +: 8] = up;
        base_len++;
      end
    end
  endfunction

  function automatic void predict_item(input logic [7:0] b, input logic nb, input logic eop);
    logic [3:0]   st;
    path_result_t r;
    item_results.delete();
    if (!nb) take_byte(b);
    if (eop) begin
      st = sticky;
      if (byte_count == 0) begin
        st = ST_EMPTY;
      end else if (st == ST_OK) begin
        st = close_segment();
        if (st == ST_OK && !emitted_any) st = ST_NORM_EMPTY;
      end
      add_result(8'h00, 1'b0, 1'b1, st);
      reset_path();
    end
    for (int i = 0; i < item_results.size(); i++) begin
      r = item_results[i];
      r.last = (i == item_results.size() - 1);
      expected_q = {expected_q, r};
    end
  endfunction

  always @(posedge clk) begin : compare_proc
    path_result_t want;
    if (rst) begin
      reset_path();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result char=%02h cv=%b vv=%b st=%0d",
                                    out_char, char_valid, verdict_valid, status_code));
        end else begin
          want = expected_q.pop_front();
          if (out_char !== want.ch)
            report_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
          if (char_valid !== want.chr)
            report_mismatch($sformatf("char_valid %b, want %b", char_valid, want.chr));
          if (verdict_valid !== want.verdict)
            report_mismatch($sformatf("verdict_valid %b, want %b", verdict_valid,
                                      want.verdict));
          if (status_code !== want.status)
            report_mismatch($sformatf("status_code %0d, want %0d", status_code,
                                      want.status));
          if (run_last !== want.last)
            report_mismatch($sformatf("run_last %b, want %b", run_last, want.last));
        end
      end
      if (in_valid && in_ready) predict_item(path_byte, no_byte, end_of_path);
    end
    outstanding <= expected_q.size();
    mismatches <= error_count;
  end

endmodule

/* verif/archive_path_sanitizer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for archive_path_sanitizer_unit: drives directed and random paths
// with random idling, and gives the verdict. Depends on aps_pkg and the checker.
module archive_path_sanitizer_unit_tb;
  import aps_pkg::*;

  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam int         RandomItems = 330;
  localparam int         CalmTail    = 50;
  localparam int         HoldAt      = 120;
  localparam int         HoldCycles  = 150;
  localparam int         StallLimit  = 1000;
  localparam int         DrainCycles = 12;

  typedef struct packed {
    logic [7:0] chr;
    logic       no_chr;
    logic       eop;
  } path_req_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] path_byte;
  logic       no_byte;
  logic       end_of_path;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       verdict_valid;
  logic [3:0] status_code;
  logic       run_last;
  int         mismatches;
  int         outstanding;

  bit         tx_gaps;
  bit         rx_gaps;
  bit         long_hold;
  int         sent_count;
  int         idle_cycles;
  path_req_t  path_items[$];
  string      dev_stems[6] = '{"CON", "PRN", "AUX", "NUL", "COM", "LPT"};
  string      bad_chars = "<>:\"|?*";

  archive_path_sanitizer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .path_byte(path_byte), .no_byte(no_byte), .end_of_path(end_of_path),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .char_valid(char_valid), .verdict_valid(verdict_valid),
    .status_code(status_code), .run_last(run_last)
  );

  archive_path_sanitizer_checker path_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .path_byte(path_byte), .no_byte(no_byte), .end_of_path(end_of_path),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .char_valid(char_valid), .verdict_valid(verdict_valid),
    .status_code(status_code), .run_last(run_last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    c = c + "A";
    if ($urandom_range(0, 1)) c = c | 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return c | 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5, 6: c = rand_letter();
      7: c = 8'($urandom_range(8'h30, 8'h39));
      8: c = $urandom_range(0, 1) ? "_" : "-";
      9: c = 8'($urandom_range(8'h80, 8'hFF));
      10: c = CH_DOT;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_sep();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    path_req_t r;
    r.chr = b;
    r.no_chr = 1'b0;
    r.eop = 1'b0;
    path_items = {path_items, r};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_name(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) add_byte(name_char());
  endtask

  // end the path on its last byte, or with a separate no-byte item
  task automatic close_path(input bit separate_end);
    path_req_t r;
    if (separate_end || path_items.size() == 0) begin
      r.chr = 8'($urandom_range(0, 255));
      r.no_chr = 1'b1;
      r.eop = 1'b1;
    end else begin
      r = path_items.pop_back();
      r.eop = 1'b1;
    end
    path_items = {path_items, r};
  endtask

  task automatic add_segment();
    int    kind;
    string stem;
    kind = $urandom_range(0, 19);
    if (kind <= 8) begin
      add_name(1, 6);
    end else if (kind == 9) begin
      add_byte(CH_DOT);
    end else if (kind == 10) begin
      add_text("..");
    end else if (kind == 11) begin
      // empty component
    end else if (kind <= 13) begin
      stem = dev_stems[$urandom_range(0, 5)];
      for (int i = 0; i < 3; i++) add_byte(mix_case(stem[i]));
      if (stem == "COM" || stem == "LPT" || $urandom_range(0, 5) == 0)
        add_byte(8'($urandom_range(8'h30, 8'h39)));
      if ($urandom_range(0, 3) == 0) add_byte(rand_letter());
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_DOT);
        repeat ($urandom_range(1, 3)) add_byte(rand_letter());
      end
    end else if (kind == 14) begin
      add_name(1, 5);
      add_byte($urandom_range(0, 1) ? CH_DOT : CH_SPACE);
    end else if (kind == 15) begin
      add_name(0, 3);
      add_byte(bad_chars[$urandom_range(0, 6)]);
      add_name(0, 3);
    end else if (kind == 16) begin
      add_name(0, 3);
      add_byte(8'($urandom_range(0, 31)));
      add_name(0, 3);
    end else if (kind == 17) begin
      repeat ($urandom_range(1, 4)) add_byte(CH_DOT);
      if ($urandom_range(0, 1)) add_name(1, 4);
    end else if (kind == 18) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_name(8, 12);
    end
  endtask

  task automatic build_path();
    int pick;
    path_items.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      if (pick < 13) begin
        add_byte(pick_sep());
      end else if (pick < 18) begin
        add_byte(rand_letter());
        add_byte(CH_COLON);
      end
      for (int i = 0; i < $urandom_range(1, 4); i++) begin
        if (i > 0) begin
          add_byte(pick_sep());
          if ($urandom_range(0, 7) == 0) add_byte(pick_sep());
        end
        add_segment();
      end
      if ($urandom_range(0, 9) == 0) add_byte(pick_sep());
    end
    close_path($urandom_range(0, 4) == 0);
  endtask

  task automatic send_req(input path_req_t r);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    path_byte <= r.chr;
    no_byte <= r.no_chr;
    end_of_path <= r.eop;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_path(input bit add_noise);
    path_req_t r;
    for (int i = 0; i < path_items.size(); i++) begin
      if (add_noise && $urandom_range(0, 24) == 0) begin
        r.chr = 8'($urandom_range(0, 255));
        r.no_chr = 1'b1;
        r.eop = 1'b0;
        send_req(r);
      end
      send_req(path_items[i]);
      if (!(path_items[i].no_chr && !path_items[i].eop)) sent_count++;
    end
  endtask

  task automatic directed_path(input string s, input bit separate_end);
    path_items.delete();
    add_text(s);
    close_path(separate_end);
    send_path(1'b0);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end else if (long_hold) begin
        long_hold = 1'b0;
        stall_left = HoldCycles;
        out_ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    path_req_t r;
    int        path_num;
    bit        hold_done;
    rst <= 1'b1;
    in_valid <= 1'b0;
    path_byte <= 8'h00;
    no_byte <= 1'b0;
    end_of_path <= 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_done = 1'b0;
    path_num = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty path, then an ignored no-byte item
    directed_path("", 1'b1);
    r.chr = 8'hA5;
    r.no_chr = 1'b1;
    r.eop = 1'b0;
    send_req(r);
    directed_path("/a", 1'b0);
    directed_path("\\x", 1'b0);
    directed_path("c:", 1'b0);
    directed_path("..", 1'b0);
    directed_path("./.b", 1'b0);
    directed_path("nuL", 1'b0);
    directed_path("a ", 1'b0);
    path_items.delete();
    add_byte(8'h00);
    close_path(1'b0);
    send_path(1'b0);
    directed_path("?", 1'b0);
    directed_path(".", 1'b0);
    path_items.delete();
    add_byte(8'hFF);
    close_path(1'b1);
    send_path(1'b0);

    sent_count = 0;
    while (sent_count < RandomItems) begin
      if (path_num % 8 == 0) begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_gaps = $urandom_range(0, 2) != 0;
      end
      if (!hold_done && sent_count >= HoldAt) begin
        hold_done = 1'b1;
        long_hold = 1'b1;
        tx_gaps = 1'b0;
      end
      if (sent_count >= RandomItems - CalmTail) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      build_path();
      send_path(1'b1);
      path_num++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
